// File: rtl/core/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that b holds in the same cycle as a.
`define VVD_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: implication");

// Check that b holds in the cycle after a.
`define VVD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

// Check that a never holds.
`define VVD_ASSERT_NEVER(label, clk, rst, a) \
   label: assert property (@(posedge clk) disable iff (rst) !(a)) \
      else $error("assertion failed: forbidden condition");

`endif

// File: rtl/core/vvd_pkg.sv
// Package for the VRL/VRT stream deframer: codes, result type and constants.
// Depends on nothing; imported by every deframer module.
package vvd_pkg;

   localparam logic [31:0] ALIGN_VRLP      = 32'h5652_4C50;
   localparam logic [31:0] ALIGN_VS49      = 32'h5653_3439;
   localparam logic [3:0]  MAX_TYPE_RESET  = 4'd5;
   localparam int          FIFO_DEPTH      = 2;
   localparam int          TDATA_W         = 72;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_INFO,
      PH_HEADER,
      PH_BODY,
      PH_UNPARSED,
      PH_DROP
   } phase_type;

   typedef enum logic [3:0] {
      ROLE_SKIP,
      ROLE_ALIGN,
      ROLE_INFO,
      ROLE_HEADER,
      ROLE_SID,
      ROLE_CID,
      ROLE_TSI,
      ROLE_TSF,
      ROLE_PAYLOAD,
      ROLE_PTRL,
      ROLE_FTRL,
      ROLE_UNPARSED
   } role_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_UNKNOWN_TYPE,
      ERR_OVERRUN,
      ERR_SHORT,
      ERR_TRUNC
   } err_type;

   typedef struct packed {
      logic trl;
      logic tsf;
      logic tsi;
      logic cid;
      logic sid;
   } fp_type;

   typedef struct packed {
      role_type    role;
      logic [31:0] data;
      logic [3:0]  ptype;
      logic [3:0]  pcount;
      logic [11:0] fcount;
      logic [15:0] wip;
      err_type     err;
      logic        eop;
      logic        eof;
   } vvd_result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } vvd_fifo_status_type;

endpackage

// File: rtl/core/vrl_vrt_stream_deframer.sv
// VRL/VRT stream deframer top level: front end, result queue and back end.
// An accepted beat is written into the result queue, then popped into the output register that drives rsp_tvalid.
// Throughput: one beat per cycle while the result queue is not full, set by the front end's per-beat state update.
// Reset (synchronous): hunting for alignment, counters zero, max_packet_type 5,
// queue and output register empty; req_tready is low while reset is high.
// Depends on vvd_pkg, vvd_front, vvd_fifo, vvd_back and assert_macros.svh.
`include "assert_macros.svh"
module vrl_vrt_stream_deframer #(
   parameter int FIFO_DEPTH = vvd_pkg::FIFO_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [3:0]                  csr_wr_data,   // max_packet_type
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,     // stream_word
   input  logic                        req_tlast,     // buffer_end
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // data_word, pkt type, pkt count, frame counter, word_in_packet,
   // error_code, end_of_packet
   output logic [vvd_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,     // end_of_frame
   output logic [3:0]                  rsp_tuser      // word_role
);
   import vvd_pkg::*;

   logic                accept;
   logic                pop;
   vvd_result_type      push_res;
   vvd_result_type      pop_res;
   vvd_fifo_status_type fifo_stat;
   phase_type           front_phase;

   assign req_tready = !fifo_stat.full && !reset;
   assign accept     = req_tvalid && req_tready;

   vvd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .in_word     (req_tdata),
      .in_last     (req_tlast),
      .res         (push_res),
      .phase       (front_phase)
   );

   vvd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_res),
      .pop       (pop),
      .pop_data  (pop_res),
      .status    (fifo_stat)
   );

   vvd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_stat),
      .fifo_data   (pop_res),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   `VVD_ASSERT_NEXT(a_last_resumes_hunt, clock, reset, accept && req_tlast, front_phase == PH_HUNT)
   `VVD_ASSERT_NEVER(a_fifo_full_and_empty, clock, reset, fifo_stat.full && fifo_stat.empty)
   `VVD_ASSERT_IMPLY(a_eof_on_trailer, clock, reset, accept && push_res.eof, push_res.role == ROLE_FTRL)
   `VVD_ASSERT_IMPLY(a_pop_not_empty, clock, reset, pop, !fifo_stat.empty)

endmodule

// File: rtl/core/vvd_front.sv
// Front end of the deframer: hunts alignment, tracks frame and packet position,
// tags each accepted beat with its role. Depends on vvd_pkg.
module vvd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [3:0]              csr_wr_data,
   input  logic                    accept,
   input  logic [31:0]             in_word,
   input  logic                    in_last,
   output vvd_pkg::vvd_result_type res,
   output vvd_pkg::phase_type      phase
);
   import vvd_pkg::*;

   phase_type   phase_ff, phase_in, phase_step;
   logic [3:0]  max_type_ff;
   logic [19:0] fl_ff, fl_in;
   logic [19:0] fwi_ff, fwi_in;
   logic [11:0] fc_ff, fc_in;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] pwi_ff, pwi_in;
   fp_type      fp_ff, fp_in;
   logic [7:0]  hdr_ff, hdr_in;

   logic [20:0] idx_p1;
   logic        trailer_slot;
   logic [3:0]  hdr_t;
   logic [15:0] hdr_len;
   fp_type      hdr_fp;
   logic [3:0]  min_len;
   logic [19:0] left;
   err_type     hdr_err;
   logic        is_align;
   logic        body_last;
   logic [19:0] info_len;
   logic        in_frame;
   err_type     err;

   function automatic role_type body_role(input fp_type fp, input logic [15:0] i,
                                          input logic [15:0] plen);
      logic [2:0] pos;
      logic       found;
      role_type   r;
      pos   = 3'd1;
      found = 1'b0;
      r     = ROLE_PAYLOAD;
      if (fp.trl && i == plen - 16'd1) begin
         r     = ROLE_PTRL;
         found = 1'b1;
      end
      if (!found && fp.sid) begin
         if (i == {13'd0, pos}) begin
            r     = ROLE_SID;
            found = 1'b1;
         end
         pos = pos + 3'd1;
      end
      if (!found && fp.cid) begin
         if (i < {13'd0, pos} + 16'd2) begin
            r     = ROLE_CID;
            found = 1'b1;
         end
         pos = pos + 3'd2;
      end
      if (!found && fp.tsi) begin
         if (i == {13'd0, pos}) begin
            r     = ROLE_TSI;
            found = 1'b1;
         end
         pos = pos + 3'd1;
      end
      if (!found && fp.tsf) begin
         if (i < {13'd0, pos} + 16'd2) begin
            r = ROLE_TSF;
         end
      end
      return r;
   endfunction

   assign idx_p1       = {1'b0, fwi_ff} + 21'd1;
   assign trailer_slot = idx_p1 >= {1'b0, fl_ff};
   assign hdr_t        = in_word[31:28];
   assign hdr_len      = in_word[15:0];
   assign hdr_fp.sid   = (hdr_t == 4'd1) || (hdr_t == 4'd3) || (hdr_t == 4'd4) ||
                         (hdr_t == 4'd5);
   assign hdr_fp.cid   = in_word[27];
   assign hdr_fp.tsi   = |in_word[23:22];
   assign hdr_fp.tsf   = |in_word[21:20];
   assign hdr_fp.trl   = (hdr_t != 4'd4) && (hdr_t != 4'd5) && in_word[26];
   assign min_len      = 4'd1 + {3'd0, hdr_fp.sid} + {2'd0, hdr_fp.cid, 1'b0} +
                         {3'd0, hdr_fp.tsi} + {2'd0, hdr_fp.tsf, 1'b0} + {3'd0, hdr_fp.trl};
   assign left         = fl_ff - 20'd1 - fwi_ff;
   assign is_align     = (in_word == ALIGN_VRLP) || (in_word == ALIGN_VS49);
   assign body_last    = ({1'b0, pwi_ff} + 17'd1) >= {1'b0, plen_ff};
   assign info_len     = (in_word[19:0] < 20'd3) ? 20'd3 : in_word[19:0];
   assign phase        = phase_ff;

   always_comb begin
      if (hdr_t > max_type_ff) begin
         hdr_err = ERR_UNKNOWN_TYPE;
      end else if (hdr_len == 16'd0) begin
         hdr_err = ERR_NONE;
      end else if ({4'd0, hdr_len} > left) begin
         hdr_err = ERR_OVERRUN;
      end else if (hdr_len < {12'd0, min_len}) begin
         hdr_err = ERR_SHORT;
      end else begin
         hdr_err = ERR_NONE;
      end
   end

   // next state
   always_comb begin
      phase_step = phase_ff;
      fl_in      = fl_ff;
      fwi_in     = fwi_ff;
      fc_in      = fc_ff;
      plen_in    = plen_ff;
      pwi_in     = pwi_ff;
      fp_in      = fp_ff;
      hdr_in     = hdr_ff;
      unique case (phase_ff)
         PH_INFO: begin
            fl_in      = info_len;
            fc_in      = in_word[31:20];
            fwi_in     = 20'd2;
            phase_step = PH_HEADER;
         end
         PH_HEADER, PH_BODY, PH_UNPARSED, PH_DROP: begin
            fwi_in = fwi_ff + 20'd1;
            if (phase_ff != PH_BODY && trailer_slot) begin
               phase_step = PH_HUNT;
            end else if (phase_ff == PH_HEADER) begin
               if (hdr_err == ERR_NONE && hdr_len == 16'd0) begin
                  phase_step = PH_UNPARSED;
               end else begin
                  hdr_in  = {hdr_t, in_word[19:16]};
                  fp_in   = hdr_fp;
                  plen_in = hdr_len;
                  if (hdr_err != ERR_NONE) begin
                     phase_step = PH_DROP;
                  end else if (hdr_len == 16'd1) begin
                     pwi_in = 16'd0;
                  end else begin
                     pwi_in     = 16'd1;
                     phase_step = PH_BODY;
                  end
               end
            end else if (phase_ff == PH_BODY) begin
               if (body_last) begin
                  pwi_in     = 16'd0;
                  phase_step = PH_HEADER;
               end else begin
                  pwi_in = pwi_ff + 16'd1;
               end
            end
         end
         default: begin
            phase_step = PH_HUNT;
            if (is_align) begin
               fwi_in     = 20'd1;
               phase_step = PH_INFO;
            end
         end
      endcase
      phase_in = in_last ? PH_HUNT : phase_step;
   end

   // outputs
   always_comb begin
      res      = '0;
      res.data = in_word;
      in_frame = 1'b1;
      err      = ERR_NONE;
      unique case (phase_ff)
         PH_INFO: begin
            res.role   = ROLE_INFO;
            res.fcount = in_word[31:20];
         end
         PH_HEADER, PH_BODY, PH_UNPARSED, PH_DROP: begin
            if (phase_ff != PH_BODY && trailer_slot) begin
               in_frame = 1'b0;
               if (phase_ff != PH_DROP) begin
                  res.role   = ROLE_FTRL;
                  res.fcount = fc_ff;
                  res.eof    = 1'b1;
               end
            end else if (phase_ff == PH_HEADER) begin
               res.fcount = fc_ff;
               if (hdr_err == ERR_NONE && hdr_len == 16'd0) begin
                  res.role = ROLE_UNPARSED;
               end else begin
                  res.role   = ROLE_HEADER;
                  res.ptype  = hdr_t;
                  res.pcount = in_word[19:16];
                  err        = hdr_err;
                  res.eop    = (hdr_err == ERR_NONE) && (hdr_len == 16'd1);
               end
            end else if (phase_ff == PH_BODY) begin
               res.fcount = fc_ff;
               res.role   = body_role(fp_ff, pwi_ff, plen_ff);
               res.ptype  = hdr_ff[7:4];
               res.pcount = hdr_ff[3:0];
               res.wip    = pwi_ff;
               res.eop    = body_last;
            end else if (phase_ff == PH_UNPARSED) begin
               res.role   = ROLE_UNPARSED;
               res.fcount = fc_ff;
            end
         end
         default: begin
            if (is_align) begin
               res.role = ROLE_ALIGN;
            end else begin
               in_frame = 1'b0;
            end
         end
      endcase
      if (in_last && in_frame && phase_step != PH_DROP && err == ERR_NONE) begin
         err = ERR_TRUNC;
      end
      res.err = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_type_ff <= MAX_TYPE_RESET;
      end else if (csr_wr_en) begin
         max_type_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         fl_ff    <= '0;
         fwi_ff   <= '0;
         fc_ff    <= '0;
         plen_ff  <= '0;
         pwi_ff   <= '0;
         fp_ff    <= '0;
         hdr_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         fl_ff    <= fl_in;
         fwi_ff   <= fwi_in;
         fc_ff    <= fc_in;
         plen_ff  <= plen_in;
         pwi_ff   <= pwi_in;
         fp_ff    <= fp_in;
         hdr_ff   <= hdr_in;
      end
   end

endmodule

// File: rtl/core/vvd_fifo.sv
// Short result queue between front and back ends of the deframer.
// Depends on vvd_pkg.
module vvd_fifo #(
   parameter int DEPTH = vvd_pkg::FIFO_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  vvd_pkg::vvd_result_type      push_data,
   input  logic                         pop,
   output vvd_pkg::vvd_result_type      pop_data,
   output vvd_pkg::vvd_fifo_status_type status
);
   import vvd_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   vvd_result_type    mem_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign status.empty = count_ff == '0;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + ADDR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + ADDR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/vvd_back.sv
// Back end of the deframer: drains the result queue into the output register
// and packs each result beat for the stream port. Depends on vvd_pkg.
module vvd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  vvd_pkg::vvd_fifo_status_type fifo_status,
   input  vvd_pkg::vvd_result_type      fifo_data,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [vvd_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic                         rsp_tlast,
   output logic [3:0]                   rsp_tuser
);
   import vvd_pkg::*;

   logic               valid_ff, valid_in;
   logic [TDATA_W-1:0] tdata_ff;
   logic               tlast_ff;
   logic [3:0]         tuser_ff;

   assign pop      = !fifo_status.empty && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tdata_ff <= {fifo_data.eop, fifo_data.err, fifo_data.wip, fifo_data.fcount,
                      fifo_data.pcount, fifo_data.ptype, fifo_data.data};
         tlast_ff <= fifo_data.eof;
         tuser_ff <= fifo_data.role;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = tuser_ff;

endmodule
